// ===== design/erm_pkg.sv =====
// ----------------------------------------------------------------------------
// erm_pkg: shared types, constants and functions
// Beat formats, CORDIC arc-tangent table and fixed-point rounding helpers
// for the Euler rotation matrix builder.
// ----------------------------------------------------------------------------
package erm_pkg;

   // number of CORDIC micro-rotations (8 to 24)
   localparam int CORDIC_STAGES = 16;
   localparam int STAGE_W       = $clog2(CORDIC_STAGES);
   localparam int ATAN_IDX_W    = 5;

   localparam int ONE_Q14     = 16384;
   localparam int PI_Q13      = 25736;
   localparam int HALF_PI_Q13 = 12868;
   localparam int GAIN_Q30    = 652032874;

   // rotation order codes
   localparam logic [1:0] KIND_ZYX = 2'd0;
   localparam logic [1:0] KIND_ZXY = 2'd1;
   localparam logic [1:0] KIND_XYZ = 2'd2;

   // lane order inside the CORDIC chain and the trig vectors
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z,
      AXIS_NONE
   } axis_type;

   typedef struct packed {
      logic        [1:0]  kind;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } rsp_type;

   // one CORDIC lane: x (cos), y (sin), residual angle z
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } lane_type;

   typedef struct packed {
      logic                vld;
      logic [1:0]          kind;
      logic [2:0]          neg;
      logic [2:0]          zero;
      lane_type [2:0]      lane;
   } cord_stage_type;

   typedef struct packed {
      logic                vld;
      logic [1:0]          kind;
      logic [2:0][15:0]    cos_v;
      logic [2:0][15:0]    sin_v;
      logic [2:0][2:0][15:0] mat;
   } mat_stage_type;

   // atan(2^-i) in Q.29, entry 0 is pi/4
   function automatic logic [29:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:    v = 30'd421657428;
         5'd1:    v = 30'd248918915;
         5'd2:    v = 30'd131521918;
         5'd3:    v = 30'd66762579;
         5'd4:    v = 30'd33510843;
         5'd5:    v = 30'd16771758;
         5'd6:    v = 30'd8387925;
         5'd7:    v = 30'd4194219;
         5'd8:    v = 30'd2097141;
         5'd9:    v = 30'd1048575;
         default: v = 30'(30'd1 << (29 - idx));
      endcase
      return v;
   endfunction

   // clamp to +-1.0 in Q1.14
   function automatic logic [15:0] sat14(input logic signed [33:0] v);
      logic [15:0] r;
      if (v > ONE_Q14) begin
         r = 16'(ONE_Q14);
      end else if (v < -ONE_Q14) begin
         r = 16'(-ONE_Q14);
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   // Q2.28 product sum back to Q1.14, round half up, then clamp
   function automatic logic [15:0] rnd_sat(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = (v + 34'sd8192) >>> 14;
      return sat14(t);
   endfunction

   // which axis a matrix step applies for a given order
   function automatic axis_type axis_for(input logic [1:0] kind, input logic [1:0] step);
      axis_type a;
      a = AXIS_NONE;
      case (kind)
         KIND_ZYX: begin
            a = (step == 2'd0) ? AXIS_Z : (step == 2'd1) ? AXIS_Y : AXIS_X;
         end
         KIND_ZXY: begin
            a = (step == 2'd0) ? AXIS_Z : (step == 2'd1) ? AXIS_X : AXIS_Y;
         end
         KIND_XYZ: begin
            a = (step == 2'd0) ? AXIS_X : (step == 2'd1) ? AXIS_Y : AXIS_Z;
         end
         default: begin
            a = AXIS_NONE;
         end
      endcase
      return a;
   endfunction

endpackage

// ===== design/erm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// erm_cordic_cell: one CORDIC micro-rotation for three angle lanes
// Registered cell; a row of these forms the sine/cosine pipeline.
// ----------------------------------------------------------------------------
module erm_cordic_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic [erm_pkg::STAGE_W-1:0]    stage_idx,
   input  erm_pkg::cord_stage_type        d_in,
   output erm_pkg::cord_stage_type        d_ff
);

   erm_pkg::cord_stage_type d_nxt;

   // rotate each lane toward zero residual angle
   always_comb begin
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic signed [33:0] at;
      d_nxt = d_in;
      at = $signed(34'(erm_pkg::atan_q29(erm_pkg::ATAN_IDX_W'(stage_idx))));
      for (int k = 0; k < 3; k++) begin
         x  = $signed(d_in.lane[k].x);
         y  = $signed(d_in.lane[k].y);
         z  = $signed(d_in.lane[k].z);
         xs = x >>> stage_idx;
         ys = y >>> stage_idx;
         if (!z[33]) begin
            d_nxt.lane[k].x = x - ys;
            d_nxt.lane[k].y = y + xs;
            d_nxt.lane[k].z = z - at;
         end else begin
            d_nxt.lane[k].x = x + ys;
            d_nxt.lane[k].y = y - xs;
            d_nxt.lane[k].z = z + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.vld <= 1'b0;
      end else if (adv) begin
         d_ff <= d_nxt;
      end
   end

endmodule

// ===== design/erm_mat_cell.sv =====
// ----------------------------------------------------------------------------
// erm_mat_cell: multiply the running matrix by one axis rotation
// Registered cell; three of these apply the factors in the chosen order.
// ----------------------------------------------------------------------------
module erm_mat_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic [1:0]              step,
   input  erm_pkg::mat_stage_type  d_in,
   output erm_pkg::mat_stage_type  d_ff
);

   erm_pkg::mat_stage_type d_nxt;

   // only the two columns of the rotation plane change
   always_comb begin
      erm_pkg::axis_type  ax;
      logic [1:0]         p;
      logic [1:0]         q;
      logic               en;
      logic signed [15:0] c;
      logic signed [15:0] s;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [33:0] np;
      logic signed [33:0] nq;
      d_nxt = d_in;
      ax = erm_pkg::axis_for(d_in.kind, step);
      en = 1'b1;
      p  = 2'd0;
      q  = 2'd1;
      c  = 16'sd0;
      s  = 16'sd0;
      case (ax)
         erm_pkg::AXIS_X: begin
            p = 2'd1; q = 2'd2;
            c = $signed(d_in.cos_v[erm_pkg::LANE_X]);
            s = $signed(d_in.sin_v[erm_pkg::LANE_X]);
         end
         erm_pkg::AXIS_Y: begin
            p = 2'd2; q = 2'd0;
            c = $signed(d_in.cos_v[erm_pkg::LANE_Y]);
            s = $signed(d_in.sin_v[erm_pkg::LANE_Y]);
         end
         erm_pkg::AXIS_Z: begin
            p = 2'd0; q = 2'd1;
            c = $signed(d_in.cos_v[erm_pkg::LANE_Z]);
            s = $signed(d_in.sin_v[erm_pkg::LANE_Z]);
         end
         default: begin
            en = 1'b0;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         a  = $signed(d_in.mat[i][p]);
         b  = $signed(d_in.mat[i][q]);
         np = 34'(a) * 34'(c) + 34'(b) * 34'(s);
         nq = 34'(b) * 34'(c) - 34'(a) * 34'(s);
         if (en) begin
            d_nxt.mat[i][p] = erm_pkg::rnd_sat(np);
            d_nxt.mat[i][q] = erm_pkg::rnd_sat(nq);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.vld <= 1'b0;
      end else if (adv) begin
         d_ff <= d_nxt;
      end
   end

endmodule

// ===== design/euler_rotation_matrix_builder.sv =====
// Registers from accepted req beat to rsp_valid: angle fold, one cell per
//   CORDIC micro-rotation, Q1.14 conversion, three matrix-product cells.
//   Throughput: one beat per cycle unless rsp_stall holds the output.
// The whole pipeline halts while a finished beat waits on rsp_stall.
// Synchronous reset clears only the valid flags of the stages.
// ----------------------------------------------------------------------------
// euler_rotation_matrix_builder: 3x3 rotation matrix from Euler angles
// Pipelined CORDIC sine/cosine for three angles, then three chained
// matrix-product cells in Z-Y-X, Z-X-Y or X-Y-Z order (kind 3: identity).
// ----------------------------------------------------------------------------
module euler_rotation_matrix_builder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  erm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output erm_pkg::rsp_type rsp_data
);

   localparam int N = erm_pkg::CORDIC_STAGES;

   logic                    adv;
   erm_pkg::cord_stage_type fold_in;
   erm_pkg::cord_stage_type chain [N+1];
   erm_pkg::mat_stage_type  conv_in;
   erm_pkg::mat_stage_type  mst [4];

   // pipeline moves unless the output beat is held
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // quadrant fold into +-pi/2 and CORDIC seed
   always_comb begin
      logic signed [2:0][15:0] ang;
      logic signed [16:0]      ae;
      logic signed [16:0]      f;
      ang[erm_pkg::LANE_X] = req_data.angle_x;
      ang[erm_pkg::LANE_Y] = req_data.angle_y;
      ang[erm_pkg::LANE_Z] = req_data.angle_z;
      fold_in.vld  = req_valid;
      fold_in.kind = req_data.kind;
      for (int k = 0; k < 3; k++) begin
         ae = 17'($signed(ang[k]));
         f  = ae;
         fold_in.neg[k]  = 1'b0;
         fold_in.zero[k] = (ae == 17'sd0);
         if (ae > erm_pkg::HALF_PI_Q13) begin
            f = ae - 17'(erm_pkg::PI_Q13);
            fold_in.neg[k] = 1'b1;
         end else if (ae < -erm_pkg::HALF_PI_Q13) begin
            f = ae + 17'(erm_pkg::PI_Q13);
            fold_in.neg[k] = 1'b1;
         end
         fold_in.lane[k].x = 34'(erm_pkg::GAIN_Q30);
         fold_in.lane[k].y = 34'sd0;
         fold_in.lane[k].z = 34'(f) <<< 16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0].vld <= 1'b0;
      end else if (adv) begin
         chain[0] <= fold_in;
      end
   end

   // CORDIC row
   for (genvar g = 0; g < N; g++) begin : g_cordic
      erm_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_idx (erm_pkg::STAGE_W'(g)),
         .d_in      (chain[g]),
         .d_ff      (chain[g+1])
      );
   end

   // CORDIC outputs to Q1.14, fold sign, zero-angle override, identity seed
   always_comb begin
      logic signed [33:0] cv;
      logic signed [33:0] sv;
      logic signed [15:0] c;
      logic signed [15:0] s;
      conv_in.vld  = chain[N].vld;
      conv_in.kind = chain[N].kind;
      for (int k = 0; k < 3; k++) begin
         cv = ($signed(chain[N].lane[k].x) + 34'sd32768) >>> 16;
         sv = ($signed(chain[N].lane[k].y) + 34'sd32768) >>> 16;
         c  = $signed(erm_pkg::sat14(cv));
         s  = $signed(erm_pkg::sat14(sv));
         if (chain[N].neg[k]) begin
            c = -c;
            s = -s;
         end
         if (chain[N].zero[k]) begin
            c = 16'(erm_pkg::ONE_Q14);
            s = 16'sd0;
         end
         conv_in.cos_v[k] = c;
         conv_in.sin_v[k] = s;
         for (int j = 0; j < 3; j++) begin
            conv_in.mat[k][j] = (k == j) ? 16'(erm_pkg::ONE_Q14) : 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mst[0].vld <= 1'b0;
      end else if (adv) begin
         mst[0] <= conv_in;
      end
   end

   // matrix-product row
   for (genvar m = 0; m < 3; m++) begin : g_mat
      erm_mat_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .step  (2'(m)),
         .d_in  (mst[m]),
         .d_ff  (mst[m+1])
      );
   end

   assign rsp_valid     = mst[3].vld;
   assign rsp_data.m00  = mst[3].mat[0][0];
   assign rsp_data.m01  = mst[3].mat[0][1];
   assign rsp_data.m02  = mst[3].mat[0][2];
   assign rsp_data.m10  = mst[3].mat[1][0];
   assign rsp_data.m11  = mst[3].mat[1][1];
   assign rsp_data.m12  = mst[3].mat[1][2];
   assign rsp_data.m20  = mst[3].mat[2][0];
   assign rsp_data.m21  = mst[3].mat[2][1];
   assign rsp_data.m22  = mst[3].mat[2][2];

   // checks
   a_hold_chain: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(chain[N]) && $stable(mst[0]))
      else $error("pipeline moved while output held");

   a_zero_ident: assert property (@(posedge clock) disable iff (reset)
      mst[0].vld && chain[N].zero[erm_pkg::LANE_X] && adv |=>
      mst[0].cos_v[erm_pkg::LANE_X] == 16'(erm_pkg::ONE_Q14) &&
      mst[0].sin_v[erm_pkg::LANE_X] == 16'd0)
      else $error("zero angle did not give identity factor");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_data.m00) <= erm_pkg::ONE_Q14 &&
                    $signed(rsp_data.m00) >= -erm_pkg::ONE_Q14 &&
                    $signed(rsp_data.m22) <= erm_pkg::ONE_Q14 &&
                    $signed(rsp_data.m22) >= -erm_pkg::ONE_Q14)
      else $error("matrix element out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !chain[0].vld)
      else $error("valid flags not cleared by reset");

endmodule

// ===== tb/euler_rotation_matrix_builder_tb.sv =====
// ----------------------------------------------------------------------------
// euler_rotation_matrix_builder_tb: self-checking bench for the matrix builder
// Drives angle sets in all rotation orders through the valid/stall handshake
// with random gaps and backpressure. A bit-true CORDIC and matrix predictor
// computes each expected matrix, and every rsp beat is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_rotation_matrix_builder_tb;

   localparam int  N_RANDOM  = 1400;
   localparam int  N_STAGES  = erm_pkg::CORDIC_STAGES;
   localparam int  DRAIN_CYC = 60;
   localparam logic [1:0] KIND_NONE = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   erm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   erm_pkg::rsp_type rsp_data;

   erm_pkg::req_type angle_sets[$];
   erm_pkg::rsp_type matrix_fifo[$];
   longint  atan_q29_tab[N_STAGES];
   int      n_errors = 0;
   int      n_sent = 0;
   int      n_checked = 0;
   int      kind_seen[4] = '{0, 0, 0, 0};
   bit      burst_mode = 1'b0;

   euler_rotation_matrix_builder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // atan(1/n) at 2^-60 scale by alternating Taylor series
   function automatic longint unsigned atan_inv_q60(input longint unsigned n);
      longint unsigned p, s, k;
      p = (64'd1 << 60) / n;
      s = 0;
      k = 0;
      while (p != 0) begin
         if (k[0] == 1'b0) s = s + p / (2 * k + 1);
         else              s = s - p / (2 * k + 1);
         p = p / (n * n);
         k++;
      end
      return s;
   endfunction

   function automatic int clamp_q14(input longint v);
      if (v > erm_pkg::ONE_Q14)  return erm_pkg::ONE_Q14;
      if (v < -erm_pkg::ONE_Q14) return -erm_pkg::ONE_Q14;
      return int'(v);
   endfunction

   // folded CORDIC sine/cosine of a Q3.13 angle, results in Q1.14
   function automatic void cordic_sincos(input int ang, output int c, output int s);
      longint x, y, z, xs, ys;
      bit     flip;
      x = erm_pkg::GAIN_Q30;
      y = 0;
      flip = 1'b0;
      if (ang > erm_pkg::HALF_PI_Q13) begin
         ang = ang - erm_pkg::PI_Q13;
         flip = 1'b1;
      end else if (ang < -erm_pkg::HALF_PI_Q13) begin
         ang = ang + erm_pkg::PI_Q13;
         flip = 1'b1;
      end
      z = longint'(ang) * 65536;
      for (int i = 0; i < N_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - atan_q29_tab[i];
         end else begin
            x = x + ys; y = y - xs; z = z + atan_q29_tab[i];
         end
      end
      c = clamp_q14((x + 32768) >>> 16);
      s = clamp_q14((y + 32768) >>> 16);
      if (flip) begin
         c = -c;
         s = -s;
      end
   endfunction

   // right-multiply the running matrix by one axis rotation; zero angle skips
   function automatic void rotate_about(inout int m[3][3], input erm_pkg::axis_type ax,
                                        input int ang);
      int     e[3][3];
      int     t[3][3];
      int     c, s, p, q;
      longint acc;
      if (ang == 0 || ax == erm_pkg::AXIS_NONE) return;
      cordic_sincos(ang, c, s);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            e[i][j] = (i == j) ? erm_pkg::ONE_Q14 : 0;
      case (ax)
         erm_pkg::AXIS_X: begin p = 1; q = 2; end
         erm_pkg::AXIS_Y: begin p = 2; q = 0; end
         default:         begin p = 0; q = 1; end
      endcase
      e[p][p] = c; e[p][q] = -s;
      e[q][p] = s; e[q][q] = c;
      t = m;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = longint'(t[i][0]) * e[0][j] + longint'(t[i][1]) * e[1][j]
                + longint'(t[i][2]) * e[2][j];
            m[i][j] = clamp_q14((acc + 8192) >>> 14);
         end
   endfunction

   function automatic erm_pkg::rsp_type rotation_matrix(input erm_pkg::req_type r);
      int               m[3][3];
      erm_pkg::rsp_type o;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m[i][j] = (i == j) ? erm_pkg::ONE_Q14 : 0;
      case (r.kind)
         erm_pkg::KIND_ZYX: begin
            rotate_about(m, erm_pkg::AXIS_Z, r.angle_z);
            rotate_about(m, erm_pkg::AXIS_Y, r.angle_y);
            rotate_about(m, erm_pkg::AXIS_X, r.angle_x);
         end
         erm_pkg::KIND_ZXY: begin
            rotate_about(m, erm_pkg::AXIS_Z, r.angle_z);
            rotate_about(m, erm_pkg::AXIS_X, r.angle_x);
            rotate_about(m, erm_pkg::AXIS_Y, r.angle_y);
         end
         erm_pkg::KIND_XYZ: begin
            rotate_about(m, erm_pkg::AXIS_X, r.angle_x);
            rotate_about(m, erm_pkg::AXIS_Y, r.angle_y);
            rotate_about(m, erm_pkg::AXIS_Z, r.angle_z);
         end
         default: begin
         end
      endcase
      o.m00 = 16'(m[0][0]); o.m01 = 16'(m[0][1]); o.m02 = 16'(m[0][2]);
      o.m10 = 16'(m[1][0]); o.m11 = 16'(m[1][1]); o.m12 = 16'(m[1][2]);
      o.m20 = 16'(m[2][0]); o.m21 = 16'(m[2][1]); o.m22 = 16'(m[2][2]);
      return o;
   endfunction

   // mostly short gaps, now and then a long one, none in burst stretches
   function automatic int idle_len();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic logic signed [15:0] rand_angle();
      int r;
      r = $urandom_range(99);
      if (r < 8)  return 16'sd0;
      if (r < 20) return 16'($urandom);
      if (r < 28) return 16'($urandom_range(12860, 12876));
      if (r < 36) return -16'($urandom_range(12860, 12876));
      return 16'($urandom_range(0, 2 * erm_pkg::PI_Q13) - erm_pkg::PI_Q13);
   endfunction

   // ------------------------------------------------------------ req driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            matrix_fifo.push_back(rotation_matrix(req_data));
            kind_seen[req_data.kind]++;
            n_sent++;
            if (n_sent % 200 == 0) burst_mode = ~burst_mode;
            req_gap = idle_len();
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (angle_sets.size() > 0) begin
               req_data  <= angle_sets.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ----------------------------------------------------------- rsp monitor
   int rsp_hold = 0;
   always @(posedge clock) begin
      erm_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (matrix_fifo.size() == 0) begin
               $error("rsp beat with no matrix expected");
               n_errors++;
            end else begin
               want = matrix_fifo.pop_front();
               if (rsp_data.m00 !== want.m00) begin
                  $error("m00 exp %0d got %0d", want.m00, rsp_data.m00); n_errors++; end
               if (rsp_data.m01 !== want.m01) begin
                  $error("m01 exp %0d got %0d", want.m01, rsp_data.m01); n_errors++; end
               if (rsp_data.m02 !== want.m02) begin
                  $error("m02 exp %0d got %0d", want.m02, rsp_data.m02); n_errors++; end
               if (rsp_data.m10 !== want.m10) begin
                  $error("m10 exp %0d got %0d", want.m10, rsp_data.m10); n_errors++; end
               if (rsp_data.m11 !== want.m11) begin
                  $error("m11 exp %0d got %0d", want.m11, rsp_data.m11); n_errors++; end
               if (rsp_data.m12 !== want.m12) begin
                  $error("m12 exp %0d got %0d", want.m12, rsp_data.m12); n_errors++; end
               if (rsp_data.m20 !== want.m20) begin
                  $error("m20 exp %0d got %0d", want.m20, rsp_data.m20); n_errors++; end
               if (rsp_data.m21 !== want.m21) begin
                  $error("m21 exp %0d got %0d", want.m21, rsp_data.m21); n_errors++; end
               if (rsp_data.m22 !== want.m22) begin
                  $error("m22 exp %0d got %0d", want.m22, rsp_data.m22); n_errors++; end
            end
         end
         // stall pattern is independent of rsp_valid
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_hold  = idle_len();
            rsp_stall <= (rsp_hold > 0);
            if (rsp_hold > 0) rsp_hold--;
         end
      end
   end

   // --------------------------------------------------------------- stimulus
   task automatic add_set(input logic [1:0] k, input int ax, input int ay, input int az);
      erm_pkg::req_type r;
      r.kind = k;
      r.angle_x = 16'(ax);
      r.angle_y = 16'(ay);
      r.angle_z = 16'(az);
      angle_sets.push_back(r);
   endtask

   initial begin
      erm_pkg::req_type r;
      for (int i = 0; i < N_STAGES; i++) begin
         longint unsigned v;
         if (i == 0) v = atan_inv_q60(2) + atan_inv_q60(3);
         else        v = atan_inv_q60(64'd1 << i);
         atan_q29_tab[i] = longint'((v + (64'd1 << 30)) >> 31);
      end

      // directed: identity, each order, fold edges, range extremes, raw patterns
      add_set(erm_pkg::KIND_ZYX, 0, 0, 0);
      add_set(KIND_NONE, 12345, -2222, 8000);
      add_set(erm_pkg::KIND_ZYX, 4000, -3000, 7000);
      add_set(erm_pkg::KIND_ZXY, 4000, -3000, 7000);
      add_set(erm_pkg::KIND_XYZ, 4000, -3000, 7000);
      add_set(erm_pkg::KIND_ZYX, erm_pkg::HALF_PI_Q13, erm_pkg::HALF_PI_Q13 + 1,
              -erm_pkg::HALF_PI_Q13 - 1);
      add_set(erm_pkg::KIND_XYZ, -erm_pkg::HALF_PI_Q13, 0, erm_pkg::HALF_PI_Q13);
      add_set(erm_pkg::KIND_ZXY, erm_pkg::PI_Q13, -erm_pkg::PI_Q13, erm_pkg::PI_Q13);
      add_set(erm_pkg::KIND_ZYX, 32767, -32768, 1);
      add_set(erm_pkg::KIND_XYZ, -1, 32767, -32768);
      add_set(erm_pkg::KIND_ZXY, 0, 6000, 0);
      add_set(erm_pkg::KIND_XYZ, 9000, 0, 0);
      add_set(erm_pkg::KIND_ZYX, 0, 0, -9000);
      add_set(KIND_NONE, 0, 0, 0);
      add_set(erm_pkg::KIND_ZXY, 16'h5555, 16'hAAAA, 16'h5555);
      add_set(erm_pkg::KIND_XYZ, 16'hAAAA, 16'h5555, 16'hAAAA);

      for (int n = 0; n < N_RANDOM; n++) begin
         r.kind    = ($urandom_range(99) < 5) ? KIND_NONE : 2'($urandom_range(2));
         r.angle_x = rand_angle();
         r.angle_y = rand_angle();
         r.angle_z = rand_angle();
         angle_sets.push_back(r);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (angle_sets.size() == 0 && !req_valid && matrix_fifo.size() == 0);
      repeat (DRAIN_CYC) @(posedge clock);
      $display("%0d angle sets sent, %0d matrices checked", n_sent, n_checked);
      $display("orders ZYX/ZXY/XYZ/none: %0d/%0d/%0d/%0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      if (n_errors == 0 && matrix_fifo.size() == 0) begin
         $display("euler_rotation_matrix_builder_tb OK");
      end else begin
         $display("euler_rotation_matrix_builder_tb NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("euler_rotation_matrix_builder_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/erm_pkg.sv
design/erm_cordic_cell.sv
design/erm_mat_cell.sv
design/euler_rotation_matrix_builder.sv
tb/euler_rotation_matrix_builder_tb.sv
